>>> rtl/cdeq_pkg.sv
// shared types and constants for the circular double-ended queue
package cdeq_pkg;

    // default number of words in the circular store
    localparam int DEPTH_DEFAULT = 8;

    // payload widths
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 4;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_REAR  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_REAR   = 2'd3
    } t_kind;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } t_status;

endpackage

>>> rtl/cdeq_if.sv
// request and response channel interfaces for the circular double-ended queue

// request channel: one queue operation
interface cdeq_req_if;
    logic                                  valid;
    logic                                  ready;
    cdeq_pkg::t_kind                       kind;
    logic signed [cdeq_pkg::DATA_W-1:0]    value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

// response channel: status, popped word and occupancy
interface cdeq_rsp_if;
    logic                                  valid;
    logic                                  ready;
    cdeq_pkg::t_status                     status;
    logic signed [cdeq_pkg::DATA_W-1:0]    popped;
    logic        [cdeq_pkg::OCC_W-1:0]     occupancy;

    modport source (output valid, output status, output popped, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input popped, input occupancy,
                    output ready);
endinterface

>>> rtl/circular_double_ended_queue.sv
// circular double-ended queue over a synchronous word memory
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------
//  i_req    | in  | valid / ready | kind, value
//  o_rsp    | out | valid / ready | status, popped, occupancy
//
// a push, an overflow or an underflow reaches the result register in the cycle after the request
// a successful pop first reads the memory into a read register (ST_READ), then loads the result register
// a new request is taken when no pop read is in flight and the result register
// is empty or being drained, so a successful pop blocks the input while its read is in flight
// i_rst_n is synchronous, active low; it empties the queue, memory is not cleared
// a stalled o_rsp holds the result register and blocks further requests
module circular_double_ended_queue #(
    parameter int DEPTH = cdeq_pkg::DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdeq_req_if.sink    i_req,
    cdeq_rsp_if.source  o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT   = CW'(1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    // word store
    logic signed [cdeq_pkg::DATA_W-1:0] mem [DEPTH];
    logic signed [cdeq_pkg::DATA_W-1:0] r_rd_data;

    // queue control state
    t_state         r_state,  n_state;
    logic [AW-1:0]  r_head,   n_head;
    logic [AW-1:0]  r_tail,   n_tail;
    logic           r_empty,  n_empty;
    logic [CW-1:0]  r_count,  n_count;

    // result register and pending pop result
    logic                                r_out_valid,  n_out_valid;
    cdeq_pkg::t_status                   r_out_status, n_out_status;
    logic signed [cdeq_pkg::DATA_W-1:0]  r_out_popped, n_out_popped;
    logic [cdeq_pkg::OCC_W-1:0]          r_out_occ,    n_out_occ;
    logic [cdeq_pkg::OCC_W-1:0]          r_pend_occ,   n_pend_occ;

    // memory access controls
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;

    logic req_acc;
    logic full;

    // request is taken only when idle and the result register frees up
    assign i_req.ready = (r_state == ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign req_acc     = i_req.valid && i_req.ready;
    assign full        = !r_empty && (r_count == FULL_CNT);

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.popped    = r_out_popped;
    assign o_rsp.occupancy = r_out_occ;

    // operation decode, pointer update and result selection
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_empty      = r_empty;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_popped = r_out_popped;
        n_out_occ    = r_out_occ;
        n_pend_occ   = r_pend_occ;
        wr_en        = 1'b0;
        wr_addr      = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;

        case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    case (i_req.kind)
                        cdeq_pkg::KIND_PUSH_FRONT,
                        cdeq_pkg::KIND_PUSH_REAR: begin
                            n_out_valid  = 1'b1;
                            n_out_popped = '0;
                            if (full) begin
                                n_out_status = cdeq_pkg::STATUS_OVERFLOW;
                            end else begin
                                n_out_status = cdeq_pkg::STATUS_OK;
                                wr_en        = 1'b1;
                                if (r_empty) begin
                                    n_head  = '0;
                                    n_tail  = '0;
                                    wr_addr = '0;
                                end else if (i_req.kind == cdeq_pkg::KIND_PUSH_FRONT) begin
                                    n_head  = (r_head == '0) ? LAST_IDX : r_head - AW'(1);
                                    wr_addr = n_head;
                                end else begin
                                    n_tail  = (r_tail == LAST_IDX) ? '0 : r_tail + AW'(1);
                                    wr_addr = n_tail;
                                end
                                n_empty = 1'b0;
                                n_count = r_count + ONE_CNT;
                            end
                            n_out_occ = cdeq_pkg::OCC_W'(n_count);
                        end
                        cdeq_pkg::KIND_POP_FRONT,
                        cdeq_pkg::KIND_POP_REAR: begin
                            if (r_empty) begin
                                n_out_valid  = 1'b1;
                                n_out_status = cdeq_pkg::STATUS_UNDERFLOW;
                                n_out_popped = '0;
                                n_out_occ    = cdeq_pkg::OCC_W'(r_count);
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = (i_req.kind == cdeq_pkg::KIND_POP_FRONT) ?
                                          r_head : r_tail;
                                if (r_count <= ONE_CNT) begin
                                    n_head  = '0;
                                    n_tail  = '0;
                                    n_empty = 1'b1;
                                    n_count = '0;
                                end else begin
                                    if (i_req.kind == cdeq_pkg::KIND_POP_FRONT) begin
                                        n_head = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
                                    end else begin
                                        n_tail = (r_tail == '0) ? LAST_IDX : r_tail - AW'(1);
                                    end
                                    n_count = r_count - ONE_CNT;
                                end
                                n_pend_occ = cdeq_pkg::OCC_W'(n_count);
                                n_state    = ST_READ;
                            end
                        end
                        default: begin
                            n_out_valid = r_out_valid && !o_rsp.ready;
                        end
                    endcase
                end
            end
            ST_READ: begin
                // read data has landed, result register is free
                n_out_valid  = 1'b1;
                n_out_status = cdeq_pkg::STATUS_OK;
                n_out_popped = r_rd_data;
                n_out_occ    = r_pend_occ;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_req.value;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_empty     <= 1'b1;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_empty     <= n_empty;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_popped <= n_out_popped;
        r_out_occ    <= n_out_occ;
        r_pend_occ   <= n_pend_occ;
    end

`ifndef SYNTHESIS
    // the empty flag tracks a zero count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty == (r_count == '0))
        else $error("empty flag disagrees with count");

    // count never goes past the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("count above depth");

    // an empty queue has both pointers at zero
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_head == '0 && r_tail == '0))
        else $error("pointers not home while empty");

    // while a pop read is in flight the result register is free
    a_read_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !r_out_valid)
        else $error("result register busy during pop read");

    // a pop read always ends with a result on the next cycle
    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("pop read did not complete");
`endif

endmodule
